>>> rtl/core/cvk_pkg.sv
// Shared types and constants of the 3x3 kernel filter unit.
`timescale 1ns / 1ps

package cvk_pkg;

   // Pixel and arithmetic widths.
   localparam int PIXEL_W  = 8;
   localparam int SEEN_W   = 2;
   localparam int SUM4_W   = PIXEL_W + 2;   // sum of four pixels
   localparam int ACC_W    = 14;            // signed weighted sum, -2040..4080
   localparam int MAG_W    = 12;            // non-negative weighted sum, 0..4080
   localparam int RECIP_W  = 15;
   localparam int PROD_W   = MAG_W + RECIP_W;

   // Division by a constant: blur is a shift, smooth and sharpen a reciprocal multiply.
   localparam int                  BLUR_SHIFT    = 4;
   localparam int                  RECIP_SHIFT   = 16;
   localparam logic [RECIP_W-1:0]  SMOOTH_RECIP  = 15'd7282;   // ceil(2^16 / 9)
   localparam logic [RECIP_W-1:0]  SHARPEN_RECIP = 15'd21846;  // ceil(2^16 / 3)
   localparam logic [MAG_W-1:0]    PIXEL_MAX     = 12'd255;
   localparam logic [SEEN_W-1:0]   WINDOW_FULL   = 2'd2;

   // Kernel codes as written to the select register.
   typedef enum logic [2:0] {
      KERNEL_BLUR    = 3'd0,
      KERNEL_SMOOTH  = 3'd1,
      KERNEL_SHARPEN = 3'd2,
      KERNEL_MEAN    = 3'd3,
      KERNEL_PASS    = 3'd4
   } kernel_type;

   // One vertical column of the window.
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bottom;
   } triplet_type;

   // Control that travels with a result through the arithmetic stages.
   typedef struct packed {
      kernel_type kernel;
      logic       last_in_row;
      logic       last_in_frame;
   } pipe_tag_type;

endpackage

>>> rtl/core/conv3x3_kernel_filter_unit.sv
// Top level of the streaming 3x3 kernel filter unit.
`timescale 1ns / 1ps

// The unit takes one column triplet per clock on the request channel and,
// from the third column of a row on, returns one filtered pixel for the column
// before it on the response channel. A result passes three registered stages after its
// beat is accepted: the corner and edge sums, then the kernel weighting, then the
// division and clamp into the output register. When the
// response side keeps ready high the unit sustains one beat per clock; a stall
// on the response side holds the three stages and backs up into req_ready.
// The window itself is a chain of two column cells that shift on every
// accepted beat. The kernel select register should be written only while no
// beat is in flight; it is sampled as each beat is accepted.

module conv3x3_kernel_filter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cvk_pkg::PIXEL_W-1:0] req_top_pixel,
   input  logic [cvk_pkg::PIXEL_W-1:0] req_mid_pixel,
   input  logic [cvk_pkg::PIXEL_W-1:0] req_bottom_pixel,
   input  logic                        req_row_start,
   input  logic                        req_row_end,
   input  logic                        req_frame_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cvk_pkg::PIXEL_W-1:0] rsp_filtered_pixel,
   output logic                        rsp_last_in_row,
   output logic                        rsp_last_in_frame,
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_wr_data
);
   import cvk_pkg::*;

   logic [2:0]              csr_kernel_ff;
   kernel_type              kernel_sel;
   logic [SEEN_W-1:0]       seen_ff;
   logic [SEEN_W-1:0]       seen_in;
   logic [SEEN_W-1:0]       seen_now;
   logic                    accept;
   logic                    produce;
   logic                    row_done;
   triplet_type             column_new;
   triplet_type             column_mid;
   triplet_type             column_old;
   pipe_tag_type            sum_tag;
   logic                    sum_valid;
   logic                    mid_valid;
   logic                    mid_ready;
   pipe_tag_type            mid_tag;
   logic signed [ACC_W-1:0] mid_acc;

   // Kernel select register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_kernel_ff <= KERNEL_BLUR;
      end else if (csr_wr_en) begin
         csr_kernel_ff <= csr_wr_data;
      end
   end

   // Codes without a kernel pass the center pixel through.
   always_comb begin
      case (csr_kernel_ff)
         KERNEL_BLUR:    kernel_sel = KERNEL_BLUR;
         KERNEL_SMOOTH:  kernel_sel = KERNEL_SMOOTH;
         KERNEL_SHARPEN: kernel_sel = KERNEL_SHARPEN;
         KERNEL_MEAN:    kernel_sel = KERNEL_MEAN;
         default:        kernel_sel = KERNEL_PASS;
      endcase
   end

   // Column count of the current row; a row start restarts it before use.
   assign accept   = req_valid && req_ready;
   assign row_done = req_row_end || req_frame_end;
   assign seen_now = req_row_start ? '0 : seen_ff;
   assign produce  = (seen_now == WINDOW_FULL);

   always_comb begin
      if (row_done) begin
         seen_in = '0;
      end else if (seen_now != WINDOW_FULL) begin
         seen_in = seen_now + 1'b1;
      end else begin
         seen_in = seen_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
   end

   // Window: the incoming column and a chain of two cells behind it.
   assign column_new.top    = req_top_pixel;
   assign column_new.mid    = req_mid_pixel;
   assign column_new.bottom = req_bottom_pixel;

   cvk_column_cell u_cell_mid (
      .clock      (clock),
      .shift_en   (accept),
      .column_in  (column_new),
      .column_out (column_mid)
   );

   cvk_column_cell u_cell_old (
      .clock      (clock),
      .shift_en   (accept),
      .column_in  (column_mid),
      .column_out (column_old)
   );

   // Only beats that complete a window enter the arithmetic stages.
   assign sum_valid             = req_valid && produce;
   assign sum_tag.kernel        = kernel_sel;
   assign sum_tag.last_in_row   = row_done;
   assign sum_tag.last_in_frame = req_frame_end;

   cvk_kernel_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (req_ready),
      .in_tag    (sum_tag),
      .col_old   (column_old),
      .col_mid   (column_mid),
      .col_new   (column_new),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_tag   (mid_tag),
      .out_acc   (mid_acc)
   );

   cvk_scale_clamp u_scale (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (mid_valid),
      .in_ready          (mid_ready),
      .in_tag            (mid_tag),
      .in_acc            (mid_acc),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .out_pixel         (rsp_filtered_pixel),
      .out_last_in_row   (rsp_last_in_row),
      .out_last_in_frame (rsp_last_in_frame)
   );

   // The column count saturates at a full window.
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3)
      else $error("column count left its range");

   // A beat that ends a row leaves the count cleared.
   a_row_clears: assert property (@(posedge clock) disable iff (reset)
      accept && row_done |=> seen_ff == '0)
      else $error("column count not cleared after row end");

   // A row start never completes a window.
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_row_start |-> !produce)
      else $error("row start produced a result");

   // The last pixel of a frame is also the last of its row.
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_in_frame |-> rsp_last_in_row)
      else $error("frame end without row end on response");

endmodule

>>> rtl/core/cvk_column_cell.sv
// One column cell of the window chain: holds a pixel triplet and hands it on.
`timescale 1ns / 1ps

module cvk_column_cell (
   input  logic                 clock,
   input  logic                 shift_en,
   input  cvk_pkg::triplet_type column_in,
   output cvk_pkg::triplet_type column_out
);
   import cvk_pkg::*;

   triplet_type column_ff;

   // Take the neighbor's column on every accepted beat.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;

endmodule

>>> rtl/core/cvk_kernel_sum.sv
// Two-stage weighted sum of the 3x3 window for the selected kernel.
`timescale 1ns / 1ps

module cvk_kernel_sum (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  cvk_pkg::pipe_tag_type            in_tag,
   input  cvk_pkg::triplet_type             col_old,
   input  cvk_pkg::triplet_type             col_mid,
   input  cvk_pkg::triplet_type             col_new,
   output logic                             out_valid,
   input  logic                             out_ready,
   output cvk_pkg::pipe_tag_type            out_tag,
   output logic signed [cvk_pkg::ACC_W-1:0] out_acc
);
   import cvk_pkg::*;

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   pipe_tag_type             s1_tag_ff;
   logic [SUM4_W-1:0]        s1_corner_ff;
   logic [SUM4_W-1:0]        s1_corner_in;
   logic [SUM4_W-1:0]        s1_edge_ff;
   logic [SUM4_W-1:0]        s1_edge_in;
   logic [PIXEL_W-1:0]       s1_center_ff;
   logic                     s1_ready;

   logic                     s2_valid_ff;
   logic                     s2_valid_in;
   pipe_tag_type             s2_tag_ff;
   logic signed [ACC_W-1:0]  s2_acc_ff;
   logic signed [ACC_W-1:0]  s2_acc_in;
   logic                     s2_ready;

   logic signed [ACC_W-1:0]  corner_ext;
   logic signed [ACC_W-1:0]  edge_ext;
   logic signed [ACC_W-1:0]  center_ext;

   // A stage takes a new beat when it is empty or its contents move on.
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // Stage one: group the window into corners, edges and center.
   assign s1_corner_in = SUM4_W'(col_old.top) + SUM4_W'(col_new.top)
                       + SUM4_W'(col_old.bottom) + SUM4_W'(col_new.bottom);
   assign s1_edge_in   = SUM4_W'(col_mid.top) + SUM4_W'(col_mid.bottom)
                       + SUM4_W'(col_old.mid) + SUM4_W'(col_new.mid);

   // Stage two: weight the groups as the kernel asks.
   assign corner_ext = $signed({{(ACC_W - SUM4_W){1'b0}}, s1_corner_ff});
   assign edge_ext   = $signed({{(ACC_W - SUM4_W){1'b0}}, s1_edge_ff});
   assign center_ext = $signed({{(ACC_W - PIXEL_W){1'b0}}, s1_center_ff});

   always_comb begin
      case (s1_tag_ff.kernel)
         KERNEL_BLUR: begin
            s2_acc_in = corner_ext + (edge_ext <<< 1) + (center_ext <<< 2);
         end
         KERNEL_SMOOTH: begin
            s2_acc_in = corner_ext + edge_ext + center_ext;
         end
         KERNEL_SHARPEN: begin
            s2_acc_in = (center_ext <<< 3) + (center_ext <<< 1) + center_ext
                      - (edge_ext <<< 1);
         end
         KERNEL_MEAN: begin
            s2_acc_in = (center_ext <<< 3) + center_ext - corner_ext - edge_ext;
         end
         default: begin
            s2_acc_in = center_ext;
         end
      endcase
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_tag_ff    <= in_tag;
         s1_corner_ff <= s1_corner_in;
         s1_edge_ff   <= s1_edge_in;
         s1_center_ff <= col_mid.mid;
      end
      if (s2_ready) begin
         s2_tag_ff <= s1_tag_ff;
         s2_acc_ff <= s2_acc_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_tag   = s2_tag_ff;
   assign out_acc   = s2_acc_ff;

endmodule

>>> rtl/core/cvk_scale_clamp.sv
// Output stage: divide by the kernel's divisor, clamp to a pixel, hold the result.
`timescale 1ns / 1ps

module cvk_scale_clamp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  cvk_pkg::pipe_tag_type            in_tag,
   input  logic signed [cvk_pkg::ACC_W-1:0] in_acc,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [cvk_pkg::PIXEL_W-1:0]      out_pixel,
   output logic                             out_last_in_row,
   output logic                             out_last_in_frame
);
   import cvk_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [PIXEL_W-1:0]   pixel_ff;
   logic [PIXEL_W-1:0]   pixel_in;
   logic                 last_row_ff;
   logic                 last_frame_ff;
   logic [MAG_W-1:0]     mag;
   logic [RECIP_W-1:0]   recip;
   logic [PROD_W-1:0]    prod;
   logic [MAG_W-1:0]     quot;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // A negative sum clamps to zero, so only the magnitude of a positive one matters.
   assign mag   = in_acc[MAG_W-1:0];
   assign recip = (in_tag.kernel == KERNEL_SHARPEN) ? SHARPEN_RECIP : SMOOTH_RECIP;
   assign prod  = PROD_W'(mag) * PROD_W'(recip);

   // Truncating division by the kernel's divisor.
   always_comb begin
      case (in_tag.kernel)
         KERNEL_BLUR: begin
            quot = mag >> BLUR_SHIFT;
         end
         KERNEL_SMOOTH, KERNEL_SHARPEN: begin
            quot = MAG_W'(prod >> RECIP_SHIFT);
         end
         default: begin
            quot = mag;
         end
      endcase
   end

   // Clamp to 0..255.
   always_comb begin
      if (in_acc[ACC_W-1]) begin
         pixel_in = '0;
      end else if (quot > PIXEL_MAX) begin
         pixel_in = PIXEL_MAX[PIXEL_W-1:0];
      end else begin
         pixel_in = quot[PIXEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         pixel_ff      <= pixel_in;
         last_row_ff   <= in_tag.last_in_row;
         last_frame_ff <= in_tag.last_in_frame;
      end
   end

   assign out_valid         = valid_ff;
   assign out_pixel         = pixel_ff;
   assign out_last_in_row   = last_row_ff;
   assign out_last_in_frame = last_frame_ff;

endmodule
